/* design/tlg_pkg.sv */
`timescale 1ns / 1ps
package tlg_pkg;

    // Grid geometry and field widths
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int FADE_BITS  = 8;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS  = 7;
    localparam int ADDR_BITS  = ROW_BITS + 1;
    localparam int MEM_DEPTH  = 2 * MAX_HEIGHT;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FADE   = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP
    } state_t;

    // Row-wide masked write into the cell store
    typedef struct packed {
        logic                                en;
        logic [ADDR_BITS-1:0]                addr;
        logic [MAX_WIDTH-1:0]                mask;
        logic [MAX_WIDTH-1:0]                alive;
        logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade;
    } store_wr_t;

    // Control shared by every column cell
    typedef struct packed {
        logic                 load_up;
        logic                 load_mid;
        logic                 load_dn;
        logic                 row_active;
        logic [FADE_BITS-1:0] fade_steps;
    } cell_ctl_t;

endpackage

/* design/toroidal_life_generation.sv */
`timescale 1ns / 1ps
// Toroidal Life engine with two banks of 64 x 64 cells (alive bit, 8-bit fade).
// Commands: a transaction is taken at a rising edge with start high and busy
// low. Write (0) stores one cell of the current bank, read (2) returns one cell,
// step (1) computes one generation into the other bank and swaps banks.
// Every transaction gives exactly one result: done is high for one cycle with
// done_command, alive_out and fade_out; the receiver cannot stall it.
// Write, read and unknown commands answer in the cycle after acceptance and
// may be issued back to back, one per cycle.
// A step walks all 64 rows; for each row it does three reads of the single
// row port (row above, row, row below), captures the last read, then does one
// row write. A row of 64 column cells computes the row in parallel.
// busy stays high through the walk; done rises in the cycle in which busy falls.
// After reset the store is swept to zero, one row per cycle over both banks,
// with busy high. Registers (APB, 0x0 width, 0x4 height, 0x8 fade steps)
// take effect at once; write them only while busy is low and no
// result is outstanding.
module toroidal_life_generation
    import tlg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           command,
    input  logic [COL_BITS-1:0]  col,
    input  logic [ROW_BITS-1:0]  row,
    input  logic                 alive_in,
    input  logic [FADE_BITS-1:0] fade_in,
    output logic                 done,
    output logic                 alive_out,
    output logic [FADE_BITS-1:0] fade_out,
    output logic [1:0]           done_command,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [2:0] PH_UP   = 3'd0;
    localparam logic [2:0] PH_MID  = 3'd1;
    localparam logic [2:0] PH_DN   = 3'd2;
    localparam logic [2:0] PH_LOAD = 3'd3;
    localparam logic [2:0] PH_WR   = 3'd4;

    state_t                 state_reg, state_next;
    logic [2:0]             phase_reg, phase_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [ADDR_BITS-1:0]   clr_reg, clr_next;
    logic                   bank_reg, bank_next;
    logic                   done_reg, done_next;
    logic [1:0]             done_cmd_reg, done_cmd_next;
    logic                   rd_flag_reg, rd_flag_next;
    logic [COL_BITS-1:0]    rd_col_reg, rd_col_next;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;
    logic [FADE_BITS-1:0]   fade_steps_reg;

    logic                   accept;
    logic                   cfg_wr;
    logic [SIZE_BITS-1:0]   w_use;
    logic [SIZE_BITS-1:0]   h_use;
    logic [ROW_BITS-1:0]    row_up;
    logic [ROW_BITS-1:0]    row_dn;
    logic [ROW_BITS-1:0]    rd_row;
    store_wr_t              wr;
    cell_ctl_t              ctl;
    logic [MAX_WIDTH-1:0]                alive_row;
    logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade_row;
    logic [MAX_WIDTH-1:0][2:0]           col_bits;
    logic [MAX_WIDTH-1:0][2:0]           left_bits;
    logic [MAX_WIDTH-1:0][2:0]           right_bits;
    logic [MAX_WIDTH-1:0]                alive_nx;
    logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade_nx;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= SIZE_BITS'(MAX_WIDTH);
            height_reg     <= SIZE_BITS'(MAX_HEIGHT);
            fade_steps_reg <= FADE_BITS'(16);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg      <= pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: height_reg     <= pwdata[SIZE_BITS-1:0];
                REG_FADE:   fade_steps_reg <= pwdata[FADE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_FADE:   prdata = 32'(fade_steps_reg);
            default:    prdata = '0;
        endcase
    end

    // Saturate the sizes in use
    assign w_use = (width_reg < 7'd3) ? 7'd3 :
                   (width_reg > SIZE_BITS'(MAX_WIDTH)) ? SIZE_BITS'(MAX_WIDTH) : width_reg;
    assign h_use = (height_reg < 7'd3) ? 7'd3 :
                   (height_reg > SIZE_BITS'(MAX_HEIGHT)) ? SIZE_BITS'(MAX_HEIGHT) : height_reg;

    // Wrapped neighbour rows
    assign row_up = (row_reg == '0) ? ROW_BITS'(h_use - 7'd1) : row_reg - 1'b1;
    assign row_dn = (SIZE_BITS'(row_reg) + 7'd1 == h_use) ? '0 : row_reg + 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_UP;
            row_reg      <= '0;
            clr_reg      <= '0;
            bank_reg     <= 1'b0;
            done_reg     <= 1'b0;
            done_cmd_reg <= CMD_WRITE;
            rd_flag_reg  <= 1'b0;
            rd_col_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            row_reg      <= row_next;
            clr_reg      <= clr_next;
            bank_reg     <= bank_next;
            done_reg     <= done_next;
            done_cmd_reg <= done_cmd_next;
            rd_flag_reg  <= rd_flag_next;
            rd_col_reg   <= rd_col_next;
        end
    end

    // Sequencer: clearing sweep, command handling, generation walk
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        row_next      = row_reg;
        clr_next      = clr_reg;
        bank_next     = bank_reg;
        done_next     = 1'b0;
        done_cmd_next = done_cmd_reg;
        rd_flag_next  = 1'b0;
        rd_col_next   = rd_col_reg;
        rd_row        = row;
        wr.en         = 1'b0;
        wr.addr       = {bank_reg, row};
        wr.mask       = MAX_WIDTH'(1) << col;
        wr.alive      = {MAX_WIDTH{alive_in}};
        wr.fade       = {MAX_WIDTH{fade_in}};
        ctl.load_up    = 1'b0;
        ctl.load_mid   = 1'b0;
        ctl.load_dn    = 1'b0;
        ctl.row_active = (SIZE_BITS'(row_reg) < h_use);
        ctl.fade_steps = fade_steps_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                wr.mask  = '1;
                wr.alive = '0;
                wr.fade  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_BITS'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    done_cmd_next = command;
                    rd_col_next   = col;
                    case (command)
                        CMD_WRITE:
                        begin
                            wr.en     = 1'b1;
                            done_next = 1'b1;
                        end
                        CMD_STEP:
                        begin
                            state_next = ST_STEP;
                            phase_next = PH_UP;
                            row_next   = '0;
                        end
                        CMD_READ:
                        begin
                            rd_flag_next = 1'b1;
                            done_next    = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                phase_next = phase_reg + 1'b1;
                case (phase_reg)
                    PH_UP:   rd_row = row_up;
                    PH_MID:
                    begin
                        rd_row      = row_reg;
                        ctl.load_up = 1'b1;
                    end
                    PH_DN:
                    begin
                        rd_row       = row_dn;
                        ctl.load_mid = 1'b1;
                    end
                    PH_LOAD:
                    begin
                        rd_row      = row_reg;
                        ctl.load_dn = 1'b1;
                    end
                    default:
                    begin
                        rd_row     = row_reg;
                        wr.en      = 1'b1;
                        wr.addr    = {~bank_reg, row_reg};
                        wr.mask    = '1;
                        wr.alive   = alive_nx;
                        wr.fade    = fade_nx;
                        phase_next = PH_UP;
                        row_next   = row_reg + 1'b1;
                        if (row_reg == ROW_BITS'(MAX_HEIGHT - 1))
                        begin
                            state_next = ST_IDLE;
                            bank_next  = ~bank_reg;
                            done_next  = 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tlg_store u_store (
        .clk       (clk),
        .wr        (wr),
        .rd_addr   ({bank_reg, rd_row}),
        .alive_row (alive_row),
        .fade_row  (fade_row)
    );

    // Row of column cells with toroidal neighbour links
    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_cell
        logic [COL_BITS-1:0] lf_idx;
        logic [COL_BITS-1:0] rt_idx;

        assign lf_idx = (c == 0) ? COL_BITS'(w_use - 7'd1) : COL_BITS'(c - 1);
        assign rt_idx = (SIZE_BITS'(c + 1) == w_use) ? '0 : COL_BITS'(c + 1);
        assign left_bits[c]  = col_bits[lf_idx];
        assign right_bits[c] = col_bits[rt_idx];

        tlg_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .col_active (SIZE_BITS'(c) < w_use),
            .alive_in   (alive_row[c]),
            .fade_in    (fade_row[c]),
            .left_bits  (left_bits[c]),
            .right_bits (right_bits[c]),
            .col_bits   (col_bits[c]),
            .alive_next (alive_nx[c]),
            .fade_next  (fade_nx[c])
        );
    end

    // Result ports
    assign done         = done_reg;
    assign done_command = done_cmd_reg;
    assign alive_out    = rd_flag_reg ? alive_row[rd_col_reg] : 1'b0;
    assign fade_out     = rd_flag_reg ? fade_row[rd_col_reg] : '0;

    // A non-step transaction answers in the next cycle
    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command != CMD_STEP) |=> (done && done_command == $past(command)))
        else $error("missing result for write, read or unknown command");

    // The last row write of a step ends it with a step result and a bank swap
    a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && phase_reg == PH_WR && row_reg == ROW_BITS'(MAX_HEIGHT - 1))
        |=> (done && done_command == CMD_STEP && bank_reg != $past(bank_reg)))
        else $error("step did not finish cleanly");

    // No result while the store is being swept
    a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done)
        else $error("result during clearing sweep");

    // The bank changes only at the end of a step
    a_bank_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_STEP) |=> $stable(bank_reg))
        else $error("bank changed outside a step");

endmodule

/* design/tlg_cell.sv */
`timescale 1ns / 1ps
module tlg_cell
    import tlg_pkg::*;
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic                 col_active,
    input  logic                 alive_in,
    input  logic [FADE_BITS-1:0] fade_in,
    input  logic [2:0]           left_bits,
    input  logic [2:0]           right_bits,
    output logic [2:0]           col_bits,
    output logic                 alive_next,
    output logic [FADE_BITS-1:0] fade_next
);

    logic                 up_reg;
    logic                 mid_reg;
    logic                 dn_reg;
    logic [FADE_BITS-1:0] fade_reg;
    logic [3:0]           count;

    // Capture this column of the three rows around the current one
    always_ff @(posedge clk)
    begin
        if (ctl.load_up)
        begin
            up_reg <= alive_in;
        end
        if (ctl.load_mid)
        begin
            mid_reg  <= alive_in;
            fade_reg <= fade_in;
        end
        if (ctl.load_dn)
        begin
            dn_reg <= alive_in;
        end
    end

    // Hand own column to the neighbours
    assign col_bits = {up_reg, mid_reg, dn_reg};

    // Count live neighbours and apply the rule
    always_comb
    begin
        count = 4'(left_bits[2]) + 4'(left_bits[1]) + 4'(left_bits[0])
              + 4'(right_bits[2]) + 4'(right_bits[1]) + 4'(right_bits[0])
              + 4'(up_reg) + 4'(dn_reg);
        alive_next = mid_reg;
        fade_next  = fade_reg;
        if (ctl.row_active && col_active)
        begin
            if (mid_reg && (count < 4'd2 || count > 4'd3))
            begin
                alive_next = 1'b0;
                fade_next  = ctl.fade_steps;
            end
            else if (!mid_reg && count == 4'd3)
            begin
                alive_next = 1'b1;
                fade_next  = '0;
            end
            else if (fade_reg != '0)
            begin
                fade_next = fade_reg - 1'b1;
            end
        end
    end

endmodule

/* design/tlg_store.sv */
`timescale 1ns / 1ps
module tlg_store
    import tlg_pkg::*;
(
    input  logic                                clk,
    input  store_wr_t                           wr,
    input  logic [ADDR_BITS-1:0]                rd_addr,
    output logic [MAX_WIDTH-1:0]                alive_row,
    output logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade_row
);

    logic [MAX_WIDTH-1:0]                alive_mem [MEM_DEPTH];
    logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade_mem  [MEM_DEPTH];
    logic [MAX_WIDTH-1:0]                alive_row_reg;
    logic [MAX_WIDTH-1:0][FADE_BITS-1:0] fade_row_reg;

    // Masked row write, registered row read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                if (wr.mask[i])
                begin
                    alive_mem[wr.addr][i] <= wr.alive[i];
                    fade_mem[wr.addr][i]  <= wr.fade[i];
                end
            end
        end
        alive_row_reg <= alive_mem[rd_addr];
        fade_row_reg  <= fade_mem[rd_addr];
    end

    assign alive_row = alive_row_reg;
    assign fade_row  = fade_row_reg;

endmodule

/* tb/toroidal_life_generation_tb.sv */
`timescale 1ns / 1ps
module toroidal_life_generation_tb;
    import tlg_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 2000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           command = CMD_WRITE;
    logic [COL_BITS-1:0]  col = '0;
    logic [ROW_BITS-1:0]  row = '0;
    logic                 alive_in = 1'b0;
    logic [FADE_BITS-1:0] fade_in = '0;
    logic                 done;
    logic                 alive_out;
    logic [FADE_BITS-1:0] fade_out;
    logic [1:0]           done_command;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [3:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                 alive;
        logic [FADE_BITS-1:0] fade;
        logic [1:0]           cmd;
    } cell_result_t;

    typedef struct {
        logic [1:0]           cmd;
        logic [COL_BITS-1:0]  c;
        logic [ROW_BITS-1:0]  r;
        logic                 alive;
        logic [FADE_BITS-1:0] fade;
        bit                   fixed;
        logic                 want_alive;
        logic [FADE_BITS-1:0] want_fade;
    } stim_row_t;

    // Shadow copy of both banks and of the registers
    logic                 shadow_alive [2][MAX_HEIGHT][MAX_WIDTH];
    logic [FADE_BITS-1:0] shadow_fade  [2][MAX_HEIGHT][MAX_WIDTH];
    logic                 bank;
    logic [6:0]           width_reg;
    logic [6:0]           height_reg;
    logic [7:0]           fade_steps_reg;

    cell_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int steps_seen = 0;
    int reads_seen = 0;
    int burst_left = 0;

    toroidal_life_generation uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .col(col), .row(row), .alive_in(alive_in),
        .fade_in(fade_in), .done(done), .alive_out(alive_out),
        .fade_out(fade_out), .done_command(done_command),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[toroidal_life_generation] ERROR");
            $finish;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result, done_command %0d", done_command);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (done_command !== want.cmd)
                begin
                    $error("done_command: expected %0d, got %0d", want.cmd, done_command);
                    errors++;
                end
                if (alive_out !== want.alive)
                begin
                    $error("alive_out: expected %0d, got %0d", want.alive, alive_out);
                    errors++;
                end
                if (fade_out !== want.fade)
                begin
                    $error("fade_out: expected %0d, got %0d", want.fade, fade_out);
                    errors++;
                end
            end
        end
    end

    function automatic int clamp_dim(logic [6:0] v);
        if (v < 7'd3) return 3;
        if (v > 7'd64) return 64;
        return int'(v);
    endfunction

    // Compute one generation into the other bank and swap
    function automatic void advance_generation();
        int w, h, up, dn, lf, rt, n;
        logic src, dst, a;
        logic [FADE_BITS-1:0] f;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        src = bank;
        dst = ~bank;
        for (int r = 0; r < MAX_HEIGHT; r++)
            for (int c = 0; c < MAX_WIDTH; c++)
            begin
                a = shadow_alive[src][r][c];
                f = shadow_fade[src][r][c];
                if (r < h && c < w)
                begin
                    up = (r == 0) ? h - 1 : r - 1;
                    dn = (r + 1 == h) ? 0 : r + 1;
                    lf = (c == 0) ? w - 1 : c - 1;
                    rt = (c + 1 == w) ? 0 : c + 1;
                    n = int'(shadow_alive[src][up][lf]) + int'(shadow_alive[src][up][c])
                        + int'(shadow_alive[src][up][rt]) + int'(shadow_alive[src][r][lf])
                        + int'(shadow_alive[src][r][rt]) + int'(shadow_alive[src][dn][lf])
                        + int'(shadow_alive[src][dn][c]) + int'(shadow_alive[src][dn][rt]);
                    if (a && (n < 2 || n > 3))
                    begin
                        a = 1'b0;
                        f = fade_steps_reg;
                    end
                    else if (!a && n == 3)
                    begin
                        a = 1'b1;
                        f = '0;
                    end
                    else if (f != '0)
                        f = f - 1'b1;
                end
                shadow_alive[dst][r][c] = a;
                shadow_fade[dst][r][c] = f;
            end
        bank = dst;
    endfunction

    // Apply one accepted command to the shadow and return its result
    function automatic cell_result_t apply_command(logic [1:0] cmd, int c, int r,
                                                   logic a, logic [FADE_BITS-1:0] f);
        cell_result_t res;
        res = '0;
        res.cmd = cmd;
        case (cmd)
            CMD_WRITE:
            begin
                shadow_alive[bank][r][c] = a;
                shadow_fade[bank][r][c] = f;
            end
            CMD_STEP: advance_generation();
            CMD_READ:
            begin
                res.alive = shadow_alive[bank][r][c];
                res.fade = shadow_fade[bank][r][c];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one command transaction, hold until taken, then predict
    task automatic issue(logic [1:0] cmd, logic [COL_BITS-1:0] c, logic [ROW_BITS-1:0] r,
                         logic a, logic [FADE_BITS-1:0] f, bit fixed = 0,
                         logic want_a = 0, logic [FADE_BITS-1:0] want_f = 0);
        cell_result_t res;
        command <= cmd;
        col <= c;
        row <= r;
        alive_in <= a;
        fade_in <= f;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        res = apply_command(cmd, int'(c), int'(r), a, f);
        if (fixed)
        begin
            res.alive = want_a;
            res.fade = want_f;
        end
        pending_results.push_back(res);
        if (cmd == CMD_STEP) steps_seen++;
        if (cmd == CMD_READ) reads_seen++;
        // Sender bursts with random gaps between them
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        else
            burst_left--;
    endtask

    // Drain, then write one register over APB
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_WIDTH:  width_reg = value[6:0];
            REG_HEIGHT: height_reg = value[6:0];
            REG_FADE:   fade_steps_reg = value[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd3;
            2: return 32'd64;
            3: return $urandom_range(65, 127) | ($urandom() & 32'hFFFF_FF80);
            default: return $urandom_range(3, 10);
        endcase
    endfunction

    stim_row_t directed[$];

    initial
    begin
        int sent, w, h, roll;
        stim_row_t s;

        for (int b = 0; b < 2; b++)
            for (int r = 0; r < MAX_HEIGHT; r++)
                for (int c = 0; c < MAX_WIDTH; c++)
                begin
                    shadow_alive[b][r][c] = 1'b0;
                    shadow_fade[b][r][c] = '0;
                end
        bank = 1'b0;
        width_reg = 7'd64;
        height_reg = 7'd64;
        fade_steps_reg = 8'd16;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: corners, extremes, unknown command, blinker on a wrap
        directed = '{
            '{CMD_READ,    6'd0,  6'd0,  1'b0, 8'd0,   1, 1'b0, 8'd0},
            '{CMD_READ,    6'd63, 6'd63, 1'b0, 8'd0,   1, 1'b0, 8'd0},
            '{CMD_WRITE,   6'd63, 6'd63, 1'b1, 8'd255, 1, 1'b0, 8'd0},
            '{CMD_READ,    6'd63, 6'd63, 1'b0, 8'd0,   1, 1'b1, 8'd255},
            '{CMD_UNKNOWN, 6'd63, 6'd63, 1'b1, 8'd255, 1, 1'b0, 8'd0},
            '{CMD_WRITE,   6'd0,  6'd0,  1'b1, 8'd7,   0, 1'b0, 8'd0},
            '{CMD_WRITE,   6'd0,  6'd1,  1'b1, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_WRITE,   6'd0,  6'd63, 1'b1, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_WRITE,   6'd40, 6'd20, 1'b1, 8'd128, 0, 1'b0, 8'd0},
            '{CMD_STEP,    6'd0,  6'd0,  1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd0,  6'd0,  1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd63, 6'd0,  1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd1,  6'd0,  1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd40, 6'd20, 1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd63, 6'd63, 1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_STEP,    6'd0,  6'd0,  1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd0,  6'd63, 1'b0, 8'd0,   0, 1'b0, 8'd0},
            '{CMD_READ,    6'd0,  6'd1,  1'b0, 8'd0,   0, 1'b0, 8'd0}
        };
        foreach (directed[i])
        begin
            s = directed[i];
            issue(s.cmd, s.c, s.r, s.alive, s.fade, s.fixed, s.want_alive, s.want_fade);
        end

        // Random phases: fresh sizes and fade, seed a pattern, evolve, probe
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_register(REG_WIDTH, pick_size());
            write_register(REG_HEIGHT, pick_size());
            case ($urandom_range(0, 3))
                0: write_register(REG_FADE, 32'd0);
                1: write_register(REG_FADE, 32'd255);
                default: write_register(REG_FADE, $urandom());
            endcase
            w = clamp_dim(width_reg);
            h = clamp_dim(height_reg);
            for (int k = 0; k < 150 && sent < RANDOM_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    issue(CMD_WRITE,
                          COL_BITS'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                 : $urandom_range(0, w - 1)),
                          ROW_BITS'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                 : $urandom_range(0, h - 1)),
                          $urandom_range(0, 2) == 0, FADE_BITS'($urandom()));
                else if (roll < 88)
                    issue(CMD_READ,
                          COL_BITS'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                 : $urandom_range(0, w)),
                          ROW_BITS'(($urandom_range(0, 9) == 0) ? $urandom()
                                                                 : $urandom_range(0, h)),
                          1'($urandom()), FADE_BITS'($urandom()));
                else if (roll < 97)
                    issue(CMD_STEP, COL_BITS'($urandom()), ROW_BITS'($urandom()),
                          1'($urandom()), FADE_BITS'($urandom()));
                else
                    issue(CMD_UNKNOWN, COL_BITS'($urandom()), ROW_BITS'($urandom()),
                          1'($urandom()), FADE_BITS'($urandom()));
                sent++;
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d random commands plus directed rows: %0d generations, %0d reads,",
                 sent, steps_seen, reads_seen);
        $display("across several grid sizes and fade settings, including clamped extremes.");
        if (errors == 0)
            $display("[toroidal_life_generation] OK");
        else
            $display("[toroidal_life_generation] ERROR");
        $finish;
    end

endmodule
